>>> src/lsb_stego_extractor_macros.svh
// assertion macros used by the lsb stego extractor top level
`ifndef LSB_STEGO_EXTRACTOR_MACROS_SVH
`define LSB_STEGO_EXTRACTOR_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define LSE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define LSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/lse_pkg.sv
// shared types and constants of the lsb stego extractor
package lse_pkg;

	localparam int HEADER_BYTES = 54;
	localparam int CODE_BYTES   = 8;

	localparam int HDR_CNT_W  = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SECRET_CODE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SECRET_LENGTH = 1'd1;

	// result kinds
	localparam logic [1:0] KIND_EXT    = 2'd0;
	localparam logic [1:0] KIND_PAY    = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// status codes
	localparam logic ST_OK       = 1'b0;
	localparam logic ST_MISMATCH = 1'b1;

	// input request held in the input register
	typedef struct packed {
		logic       valid;
		logic [7:0] image_byte;
		logic       frame_start;
	} in_item_t;

	// result request from the parser
	typedef struct packed {
		logic       valid;
		logic [7:0] out_byte;
		logic [1:0] out_kind;
		logic       status_code;
		logic       last;
	} res_t;

endpackage

>>> src/lse_in_if.sv
// input channel: image bytes with frame start marker
interface lse_in_if;
	import lse_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] image_byte;
	logic       frame_start;

	modport source (output valid, output image_byte, output frame_start, input ready);
	modport sink (input valid, input image_byte, input frame_start, output ready);
endinterface

>>> src/lse_out_if.sv
// output channel: decoded bytes and status
interface lse_out_if;
	import lse_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] out_kind;
	logic       status_code;
	logic       last;

	modport source (output valid, output out_byte, output out_kind, output status_code,
		output last, input ready);
	modport sink (input valid, input out_byte, input out_kind, input status_code,
		input last, output ready);
endinterface

>>> src/lse_in_stage.sv
// input register stage of the lsb stego extractor
module lse_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	lse_in_if.sink           image,
	input  logic             advance,
	output lse_pkg::in_item_t item_s1
);
	import lse_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fs_s1;

	// take a new request whenever the register is empty or the held one moves on
	assign image.ready = !valid_s1 || advance;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (image.ready) begin
			valid_s1 <= image.valid;
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (image.valid && image.ready) begin
			byte_s1 <= image.image_byte;
			fs_s1   <= image.frame_start;
		end
	end

	assign item_s1 = '{valid: valid_s1, image_byte: byte_s1, frame_start: fs_s1};
endmodule

>>> src/lse_parser.sv
// field parser: header skip, bit gathering, secret check and byte output
module lse_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lse_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lse_pkg::CFG_DATA_W-1:0] cfg_data,
	input  lse_pkg::in_item_t              item_s1,
	input  logic                           advance,
	output lse_pkg::res_t                  res
);
	import lse_pkg::*;

	localparam logic [2:0] PH_HDR  = 3'd0;
	localparam logic [2:0] PH_SLEN = 3'd1;
	localparam logic [2:0] PH_SEC  = 3'd2;
	localparam logic [2:0] PH_XLEN = 3'd3;
	localparam logic [2:0] PH_XDAT = 3'd4;
	localparam logic [2:0] PH_PLEN = 3'd5;
	localparam logic [2:0] PH_PDAT = 3'd6;
	localparam logic [2:0] PH_DONE = 3'd7;

	logic [63:0]          secret_code_q;
	logic [3:0]           secret_length_q;

	logic [2:0]           phase_q, phase_n;
	logic [HDR_CNT_W-1:0] hc_q, hc_n;
	logic [4:0]           bc_q, bc_n;
	logic [31:0]          gs_q, gs_n;
	logic [31:0]          br_q, br_n;
	logic [31:0]          seen_q, seen_n;
	logic [3:0]           ci_q, ci_n;
	logic                 match_q, match_n;

	logic                 fire;
	logic                 take;
	logic                 fin;
	logic                 sec_ok;
	logic [31:0]          gs_w;
	logic [31:0]          val;
	logic [5:0]           bc_w;
	logic [5:0]           need;
	logic [7:0]           code_byte;

	assign fire = item_s1.valid && advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			secret_code_q   <= '0;
			secret_length_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SECRET_CODE:   secret_code_q   <= cfg_data;
				REG_SECRET_LENGTH: secret_length_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// one step of the parser for the held byte
	always_comb begin
		phase_n   = item_s1.frame_start ? PH_HDR : phase_q;
		hc_n      = item_s1.frame_start ? '0 : hc_q;
		bc_n      = item_s1.frame_start ? '0 : bc_q;
		gs_n      = item_s1.frame_start ? '0 : gs_q;
		br_n      = item_s1.frame_start ? '0 : br_q;
		seen_n    = item_s1.frame_start ? '0 : seen_q;
		ci_n      = item_s1.frame_start ? '0 : ci_q;
		match_n   = item_s1.frame_start ? 1'b1 : match_q;
		res       = '0;
		take      = 1'b1;
		fin       = 1'b0;
		sec_ok    = 1'b0;
		gs_w      = '0;
		val       = '0;
		bc_w      = '0;
		need      = 6'd8;
		code_byte = '0;

		// header skip
		if (phase_n == PH_HDR) begin
			if (hc_n < HDR_CNT_W'(HEADER_BYTES)) begin
				hc_n = hc_n + HDR_CNT_W'(1);
				take = 1'b0;
			end else begin
				phase_n = PH_SLEN;
			end
		end

		if (take && phase_n != PH_DONE) begin
			gs_w = {gs_n[30:0], item_s1.image_byte[0]};
			bc_w = {1'b0, bc_n} + 6'd1;
			need = (phase_n == PH_SLEN || phase_n == PH_XLEN || phase_n == PH_PLEN)
				? 6'd32 : 6'd8;
			if (bc_w < need) begin
				gs_n = gs_w;
				bc_n = bc_w[4:0];
			end else begin
				bc_n = '0;
				gs_n = '0;
				val  = gs_w;
				unique case (phase_n)
					PH_SLEN: begin
						seen_n  = val;
						br_n    = val;
						ci_n    = '0;
						match_n = 1'b1;
						if (val == '0) begin
							fin = 1'b1;
						end else begin
							phase_n = PH_SEC;
						end
					end
					PH_SEC: begin
						// expected code byte at the current secret position
						code_byte = secret_code_q[{ci_n[2:0], 3'b000} +: 8];
						if (ci_n < 4'(CODE_BYTES)) begin
							if (code_byte != val[7:0]) begin
								match_n = 1'b0;
							end
						end else begin
							match_n = 1'b0;
						end
						if (ci_n != 4'hF) begin
							ci_n = ci_n + 4'd1;
						end
						br_n = br_n - 32'd1;
						if (br_n == '0) begin
							fin = 1'b1;
						end
					end
					PH_XLEN: begin
						br_n    = val;
						phase_n = (val != '0) ? PH_XDAT : PH_PLEN;
					end
					PH_XDAT: begin
						br_n = br_n - 32'd1;
						if (br_n == '0) begin
							phase_n = PH_PLEN;
						end
						res = '{valid: 1'b1, out_byte: val[7:0], out_kind: KIND_EXT,
							status_code: ST_OK, last: 1'b0};
					end
					PH_PLEN: begin
						if (val == '0) begin
							phase_n = PH_DONE;
							res = '{valid: 1'b1, out_byte: 8'd0, out_kind: KIND_STATUS,
								status_code: ST_OK, last: 1'b1};
						end else begin
							br_n    = val;
							phase_n = PH_PDAT;
						end
					end
					PH_PDAT: begin
						br_n = br_n - 32'd1;
						if (br_n == '0) begin
							phase_n = PH_DONE;
						end
						res = '{valid: 1'b1, out_byte: val[7:0], out_kind: KIND_PAY,
							status_code: ST_OK, last: (br_n == '0)};
					end
					default: begin
						phase_n = PH_DONE;
					end
				endcase

				// secret check at the end of the secret field
				if (fin) begin
					sec_ok = match_n && (seen_n == {28'd0, secret_length_q})
						&& (secret_length_q <= 4'(CODE_BYTES));
					if (sec_ok) begin
						phase_n = PH_XLEN;
					end else begin
						phase_n = PH_DONE;
						res = '{valid: 1'b1, out_byte: 8'd0, out_kind: KIND_STATUS,
							status_code: ST_MISMATCH, last: 1'b1};
					end
				end
			end
		end

		if (!fire) begin
			res.valid = 1'b0;
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			hc_q    <= '0;
			bc_q    <= '0;
			gs_q    <= '0;
			br_q    <= '0;
			seen_q  <= '0;
			ci_q    <= '0;
			match_q <= 1'b1;
		end else if (fire) begin
			phase_q <= phase_n;
			hc_q    <= hc_n;
			bc_q    <= bc_n;
			gs_q    <= gs_n;
			br_q    <= br_n;
			seen_q  <= seen_n;
			ci_q    <= ci_n;
			match_q <= match_n;
		end
	end
endmodule

>>> src/lse_out_stage.sv
// result register of the lsb stego extractor
module lse_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  lse_pkg::res_t res,
	output logic          advance,
	lse_out_if.source     result
);
	import lse_pkg::*;

	logic       valid_q;
	logic [7:0] byte_q;
	logic [1:0] kind_q;
	logic       status_q;
	logic       last_q;

	// register is free when empty or being taken
	assign advance = !valid_q || result.ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= res.valid;
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			byte_q   <= res.out_byte;
			kind_q   <= res.out_kind;
			status_q <= res.status_code;
			last_q   <= res.last;
		end
	end

	assign result.valid       = valid_q;
	assign result.out_byte    = byte_q;
	assign result.out_kind    = kind_q;
	assign result.status_code = status_q;
	assign result.last        = last_q;
endmodule

>>> src/lsb_stego_extractor.sv
// top level of the lsb stego extractor
//
// image carries one file byte per request, frame_start set on the first byte
// of each file. the first 54 bytes are skipped, then bit 0 of each byte is
// gathered msb first into: secret length, secret, extension length, extension
// bytes, payload length, payload bytes.
// result carries one request per extension or payload byte, or a status-only
// request (secret mismatch, or empty payload); last marks the final one.
// secret_code and secret_length are written through cfg_we/cfg_index/cfg_data;
// the user must write them while the block is idle, the block does not enforce it.
// an accepted byte is held in the input register; the parser result for it is
// loaded into the result register when that register is free, and offered there.
// throughput: one byte per cycle while result is not stalled; the parser step is
// combinational shift, count and compare logic.
// reset clears the parse state to header skip and both config registers.
// when result stalls, the result register holds and the input register takes
// one more byte if it is empty, then image.ready drops until result is taken.
`include "lsb_stego_extractor_macros.svh"

module lsb_stego_extractor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lse_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lse_pkg::CFG_DATA_W-1:0] cfg_data,
	lse_in_if.sink                         image,
	lse_out_if.source                      result
);
	import lse_pkg::*;

	in_item_t item_s1;
	res_t     res;
	logic     advance;

	lse_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.image   (image),
		.advance (advance),
		.item_s1 (item_s1)
	);

	lse_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item_s1   (item_s1),
		.advance   (advance),
		.res       (res)
	);

	lse_out_stage u_out_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.res     (res),
		.advance (advance),
		.result  (result)
	);

	// stalled output with a full input register blocks new requests
	`LSE_ASSERT_NOW(a_stall_blocks, result.valid && !result.ready && item_s1.valid,
		!image.ready, "input accepted while both stages are full")

	// status-only results close the file and carry no byte
	`LSE_ASSERT_NOW(a_status_last, result.valid && result.out_kind == KIND_STATUS,
		result.last && result.out_byte == 8'd0, "status result without last or with data")

	// no result appears without a held input request
	`LSE_ASSERT_NEXT(a_no_invented, !result.valid && !item_s1.valid,
		!result.valid, "result produced with no input request")
endmodule
